// File: rtl/core/fpa_pkg.sv
// shared types and constants of the fixed-point alu
`timescale 1ns / 1ps
`default_nettype none
package fpa_pkg;

	localparam logic [4:0] CMD_ADD        = 5'd0;
	localparam logic [4:0] CMD_SUB        = 5'd1;
	localparam logic [4:0] CMD_MUL        = 5'd2;
	localparam logic [4:0] CMD_DIV        = 5'd3;
	localparam logic [4:0] CMD_GT         = 5'd4;
	localparam logic [4:0] CMD_LT         = 5'd5;
	localparam logic [4:0] CMD_LE         = 5'd6;
	localparam logic [4:0] CMD_GE         = 5'd7;
	localparam logic [4:0] CMD_EQ         = 5'd8;
	localparam logic [4:0] CMD_NE         = 5'd9;
	localparam logic [4:0] CMD_MIN        = 5'd10;
	localparam logic [4:0] CMD_MAX        = 5'd11;
	localparam logic [4:0] CMD_INC        = 5'd12;
	localparam logic [4:0] CMD_DEC        = 5'd13;
	localparam logic [4:0] CMD_FROM_INT   = 5'd14;
	localparam logic [4:0] CMD_TO_INT     = 5'd15;
	localparam logic [4:0] CMD_FROM_FLOAT = 5'd16;
	localparam logic [4:0] CMD_TO_FLOAT   = 5'd17;

	localparam logic [1:0] ERR_NONE     = 2'd0;
	localparam logic [1:0] ERR_DIV_ZERO = 2'd1;
	localparam logic [1:0] ERR_FLOAT    = 2'd2;

	localparam int IN_W  = 104;
	localparam int OUT_W = 72;

	// per-item state carried alongside the divider
	typedef struct packed {
		logic [4:0]  cmd;
		logic [31:0] res;
		logic        flag;
		logic [1:0]  err;
		logic        tf_sign;
		logic        tf_zero;
		logic [31:0] tf_mag;
		logic [4:0]  tf_p;
		logic        div_neg;
		logic        div_zero;
	} side_t;

endpackage
`default_nettype wire

// File: rtl/core/fixed_point_alu.sv
// fixed_point_alu: pipelined signed 32-bit fixed-point alu
//
// channels: s_axis carries one command with two raw operands and a float
// bit pattern per transfer; m_axis returns one result per transfer, in order
// - add, subtract, compare, min/max, inc/dec and int conversions finish in
//   the first stage; multiply uses one 32x32 multiplier in that stage
// - divide runs a restoring divider of (32+FRAC_BITS) quotient bits, four
//   bits per stage, so ceil((32+FRAC_BITS)/4) stages (10 at FRAC_BITS = 8)
// - fixed to float finds the leading one in the first stage and normalises
//   and rounds in the last stage
// path: every command passes through the first stage, the divider stages and the last stage
// throughput: one transfer per cycle while the output is not stalled, the pipeline being fully occupied
// stall: all stages advance together; while the output holds a result that
// is not taken, the whole pipeline holds and s_axis_tready is low, nothing
// is lost or repeated
// reset: arst_n clears all valid bits, the pipeline starts empty
`timescale 1ns / 1ps
`default_nettype none
module fixed_point_alu #(
	parameter int FRAC_BITS = 8
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      s_axis_tvalid,
	output logic                           s_axis_tready,
	// command[4:0], operand_a[36:5], operand_b[68:37], float_in[100:69]
	input  wire logic [fpa_pkg::IN_W-1:0]  s_axis_tdata,
	output logic                           m_axis_tvalid,
	input  wire logic                      m_axis_tready,
	// result_raw[31:0], compare_flag[32], float_out[64:33], error_code[66:65]
	output logic [fpa_pkg::OUT_W-1:0]      m_axis_tdata
);

	localparam int DIV_W      = 32 + FRAC_BITS;
	localparam int DIV_STAGES = (DIV_W + 3) / 4;
	localparam int W_PAD      = DIV_STAGES * 4;

	// pipeline advance: last register empty or being drained
	logic en;

	logic                v_c    [DIV_STAGES+1];
	fpa_pkg::side_t      side_c [DIV_STAGES+1];
	logic [W_PAD-1:0]    dvd_c  [DIV_STAGES+1];
	logic [31:0]         dsr_c  [DIV_STAGES+1];
	logic [31:0]         rem_c  [DIV_STAGES+1];
	logic [31:0]         quo_c  [DIV_STAGES+1];

	logic        out_v;
	logic [31:0] res, fout;
	logic        flag;
	logic [1:0]  err;

	assign en            = !out_v || m_axis_tready;
	assign s_axis_tready = en;

	fpa_front #(.FRAC_BITS(FRAC_BITS), .W_PAD(W_PAD)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (s_axis_tvalid),
		.command   (s_axis_tdata[4:0]),
		.operand_a (s_axis_tdata[36:5]),
		.operand_b (s_axis_tdata[68:37]),
		.float_in  (s_axis_tdata[100:69]),
		.v_s1      (v_c[0]),
		.side_s1   (side_c[0]),
		.dvd_s1    (dvd_c[0]),
		.dsr_s1    (dsr_c[0])
	);

	// divider starts with empty remainder and quotient
	assign rem_c[0] = 32'd0;
	assign quo_c[0] = 32'd0;

	for (genvar i = 0; i < DIV_STAGES; i++) begin : g_div
		fpa_div_stage #(.W_PAD(W_PAD)) u_stage (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.v_in     (v_c[i]),
			.side_in  (side_c[i]),
			.dvd_in   (dvd_c[i]),
			.dsr_in   (dsr_c[i]),
			.rem_in   (rem_c[i]),
			.quo_in   (quo_c[i]),
			.v_out    (v_c[i+1]),
			.side_out (side_c[i+1]),
			.dvd_out  (dvd_c[i+1]),
			.dsr_out  (dsr_c[i+1]),
			.rem_out  (rem_c[i+1]),
			.quo_out  (quo_c[i+1])
		);
	end

	fpa_back #(.FRAC_BITS(FRAC_BITS)) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.v_in    (v_c[DIV_STAGES]),
		.side_in (side_c[DIV_STAGES]),
		.quo_in  (quo_c[DIV_STAGES]),
		.v_q     (out_v),
		.res_q   (res),
		.flag_q  (flag),
		.fout_q  (fout),
		.err_q   (err)
	);

	assign m_axis_tvalid = out_v;
	assign m_axis_tdata  = {5'd0, err, fout, flag, res};

	// a held result blocks new input
	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
		else $error("input accepted while output stalled");

	// divide by zero always returns zero
	a_div_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && err == fpa_pkg::ERR_DIV_ZERO |-> res == 32'd0)
		else $error("divide by zero with non-zero result");

	// a float result comes only from to_float, never with a raw result
	a_float_only: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && fout != 32'd0 |-> res == 32'd0 && err == fpa_pkg::ERR_NONE)
		else $error("float result mixed with other fields");

	// comparisons give no raw result
	a_flag_only: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && flag |-> res == 32'd0 && fout == 32'd0)
		else $error("compare flag mixed with other fields");

endmodule
`default_nettype wire

// File: rtl/core/fpa_front.sv
// first stage: simple ops, multiply, float decode, divider set-up
`timescale 1ns / 1ps
`default_nettype none
module fpa_front #(
	parameter int FRAC_BITS = 8,
	parameter int W_PAD = 40
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                en,
	input  wire logic                in_valid,
	input  wire logic [4:0]          command,
	input  wire logic signed [31:0]  operand_a,
	input  wire logic signed [31:0]  operand_b,
	input  wire logic [31:0]         float_in,
	output logic                     v_s1,
	output fpa_pkg::side_t           side_s1,
	output logic [W_PAD-1:0]         dvd_s1,
	output logic [31:0]              dsr_s1
);

	fpa_pkg::side_t   side_d;
	logic signed [63:0] prod;
	logic [31:0]      abs_a, abs_b;
	logic [31:0]      ff_res;
	logic             ff_err;
	logic [7:0]       expo;
	logic [23:0]      man24;
	logic [7:0]       e_eff;
	logic signed [10:0] sh, nsh;
	logic [55:0]      wide;
	logic [23:0]      t;
	logic [32:0]      mag33;
	logic             lt;

	assign prod  = operand_a * operand_b;
	assign abs_a = operand_a[31] ? 32'(-operand_a) : operand_a;
	assign abs_b = operand_b[31] ? 32'(-operand_b) : operand_b;
	assign lt    = operand_a < operand_b;

	// float bits to fixed, round half away from zero
	always_comb begin
		expo   = float_in[30:23];
		man24  = (expo == 8'd0) ? {1'b0, float_in[22:0]} : {1'b1, float_in[22:0]};
		e_eff  = (expo == 8'd0) ? 8'd1 : expo;
		sh     = $signed({3'b0, e_eff}) - 11'sd150 + $signed(11'(FRAC_BITS));
		nsh    = -sh;
		wide   = {32'b0, man24} << sh[4:0];
		t      = man24 >> 5'(nsh - 11'sd1);
		ff_res = 32'd0;
		ff_err = 1'b0;
		if (sh >= 11'sd0) begin
			if (sh >= 11'sd32 || (|wide[55:32]))
				mag33 = 33'h1_0000_0000;
			else
				mag33 = {1'b0, wide[31:0]};
		end else if (nsh > 11'sd25) begin
			mag33 = 33'd0;
		end else begin
			mag33 = 33'(t >> 1) + 33'(t[0]);
		end
		if (expo == 8'hFF) begin
			ff_err = 1'b1;
			if (float_in[22:0] != 23'd0)
				ff_res = 32'd0;
			else
				ff_res = float_in[31] ? 32'h8000_0000 : 32'h7FFF_FFFF;
		end else if (float_in[31]) begin
			if (mag33 > 33'h0_8000_0000) begin
				ff_err = 1'b1;
				ff_res = 32'h8000_0000;
			end else begin
				ff_res = 32'(-mag33[31:0]);
			end
		end else begin
			if (mag33 > 33'h0_7FFF_FFFF) begin
				ff_err = 1'b1;
				ff_res = 32'h7FFF_FFFF;
			end else begin
				ff_res = mag33[31:0];
			end
		end
	end

	always_comb begin
		side_d          = '0;
		side_d.cmd      = command;
		side_d.tf_sign  = operand_a[31];
		side_d.tf_mag   = abs_a;
		side_d.tf_zero  = (abs_a == 32'd0);
		side_d.div_neg  = operand_a[31] ^ operand_b[31];
		side_d.div_zero = (operand_b == 32'sd0);
		for (int i = 0; i < 32; i++) begin
			if (abs_a[i])
				side_d.tf_p = 5'(i);
		end
		case (command)
			fpa_pkg::CMD_ADD:      side_d.res = 32'(operand_a + operand_b);
			fpa_pkg::CMD_SUB:      side_d.res = 32'(operand_a - operand_b);
			fpa_pkg::CMD_MUL:      side_d.res = prod[FRAC_BITS+31:FRAC_BITS];
			fpa_pkg::CMD_GT:       side_d.flag = operand_a > operand_b;
			fpa_pkg::CMD_LT:       side_d.flag = lt;
			fpa_pkg::CMD_LE:       side_d.flag = operand_a <= operand_b;
			fpa_pkg::CMD_GE:       side_d.flag = operand_a >= operand_b;
			fpa_pkg::CMD_EQ:       side_d.flag = operand_a == operand_b;
			fpa_pkg::CMD_NE:       side_d.flag = operand_a != operand_b;
			fpa_pkg::CMD_MIN:      side_d.res = lt ? operand_a : operand_b;
			fpa_pkg::CMD_MAX:      side_d.res = lt ? operand_b : operand_a;
			fpa_pkg::CMD_INC:      side_d.res = 32'(operand_a + 32'sd1);
			fpa_pkg::CMD_DEC:      side_d.res = 32'(operand_a - 32'sd1);
			fpa_pkg::CMD_FROM_INT: side_d.res = operand_a << FRAC_BITS;
			fpa_pkg::CMD_TO_INT:   side_d.res = operand_a >>> FRAC_BITS;
			fpa_pkg::CMD_FROM_FLOAT: begin
				side_d.res = ff_res;
				side_d.err = ff_err ? fpa_pkg::ERR_FLOAT : fpa_pkg::ERR_NONE;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (en)
			v_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1 <= side_d;
			dvd_s1  <= {{(W_PAD-32){1'b0}}, abs_a} << FRAC_BITS;
			dsr_s1  <= abs_b;
		end
	end

endmodule
`default_nettype wire

// File: rtl/core/fpa_div_stage.sv
// one register stage of the restoring divider, four quotient bits
`timescale 1ns / 1ps
`default_nettype none
module fpa_div_stage #(
	parameter int W_PAD = 40
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire logic              v_in,
	input  wire fpa_pkg::side_t    side_in,
	input  wire logic [W_PAD-1:0]  dvd_in,
	input  wire logic [31:0]       dsr_in,
	input  wire logic [31:0]       rem_in,
	input  wire logic [31:0]       quo_in,
	output logic                   v_out,
	output fpa_pkg::side_t         side_out,
	output logic [W_PAD-1:0]       dvd_out,
	output logic [31:0]            dsr_out,
	output logic [31:0]            rem_out,
	output logic [31:0]            quo_out
);

	localparam int STEPS = 4;

	logic [W_PAD-1:0] dvd_d;
	logic [31:0]      rem_d, quo_d;
	logic [32:0]      trial;

	always_comb begin
		dvd_d = dvd_in;
		rem_d = rem_in;
		quo_d = quo_in;
		trial = '0;
		for (int k = 0; k < STEPS; k++) begin
			trial = {rem_d, dvd_d[W_PAD-1]};
			dvd_d = dvd_d << 1;
			if (trial >= {1'b0, dsr_in}) begin
				rem_d = 32'(trial - {1'b0, dsr_in});
				quo_d = {quo_d[30:0], 1'b1};
			end else begin
				rem_d = trial[31:0];
				quo_d = {quo_d[30:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_out <= 1'b0;
		else if (en)
			v_out <= v_in;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_out <= side_in;
			dvd_out  <= dvd_d;
			dsr_out  <= dsr_in;
			rem_out  <= rem_d;
			quo_out  <= quo_d;
		end
	end

endmodule
`default_nettype wire

// File: rtl/core/fpa_back.sv
// last stage: quotient sign, fixed to float rounding, output register
`timescale 1ns / 1ps
`default_nettype none
module fpa_back #(
	parameter int FRAC_BITS = 8
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            en,
	input  wire logic            v_in,
	input  wire fpa_pkg::side_t  side_in,
	input  wire logic [31:0]     quo_in,
	output logic                 v_q,
	output logic [31:0]          res_q,
	output logic                 flag_q,
	output logic [31:0]          fout_q,
	output logic [1:0]           err_q
);

	logic [31:0] norm;
	logic [23:0] q;
	logic        up;
	logic [24:0] qn;
	logic [8:0]  bexp;
	logic [31:0] fout_d, res_d;
	logic [1:0]  err_d;

	always_comb begin
		norm   = side_in.tf_mag << (5'd31 - side_in.tf_p);
		q      = norm[31:8];
		up     = norm[7] & ((|norm[6:0]) | q[0]);
		qn     = {1'b0, q} + 25'(up);
		bexp   = {4'b0, side_in.tf_p} + 9'd127 - 9'(FRAC_BITS) + 9'(qn[24]);
		fout_d = 32'd0;
		res_d  = side_in.res;
		err_d  = side_in.err;
		case (side_in.cmd)
			fpa_pkg::CMD_DIV: begin
				if (side_in.div_zero) begin
					res_d = 32'd0;
					err_d = fpa_pkg::ERR_DIV_ZERO;
				end else begin
					res_d = side_in.div_neg ? 32'(-quo_in) : quo_in;
				end
			end
			fpa_pkg::CMD_TO_FLOAT: begin
				if (!side_in.tf_zero)
					fout_d = {side_in.tf_sign, bexp[7:0], qn[24] ? 23'd0 : qn[22:0]};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_q <= 1'b0;
		else if (en)
			v_q <= v_in;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_q  <= res_d;
			flag_q <= side_in.flag;
			fout_q <= fout_d;
			err_q  <= err_d;
		end
	end

endmodule
`default_nettype wire
